@@ hdl/sli_pkg.sv @@
// Types and constants shared by the sorted list cells and the top level.
package sli_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned STAT_W  = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_e;

  localparam logic [STAT_W-1:0] ST_DONE = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0]          req_type;
    logic signed [VALUE_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [STAT_W-1:0]         status;
    logic [COUNT_W-1:0]        count;
    logic signed [VALUE_W-1:0] largest;
    logic signed [VALUE_W-1:0] smallest;
  } out_t;

  typedef struct packed {
    logic                      ins;
    logic                      rem;
    logic                      found;
    logic signed [VALUE_W-1:0] value;
  } cell_op_t;

endpackage

@@ hdl/sli_cell.sv @@
// One list cell: holds an entry and shifts with its neighbors on insert and remove.
module sli_cell (
  input  logic                              clk_i,
  input  sli_pkg::cell_op_t                 op_i,
  input  logic                              valid_i,
  input  logic                              left_keep_i,
  input  logic signed [sli_pkg::VALUE_W-1:0] left_data_i,
  input  logic signed [sli_pkg::VALUE_W-1:0] right_data_i,
  output logic                              keep_o,
  output logic                              match_o,
  output logic signed [sli_pkg::VALUE_W-1:0] data_o
);
  import sli_pkg::*;

  logic signed [VALUE_W-1:0] data_q, data_d;

  always_comb begin
    keep_o  = valid_i && (op_i.value < data_q);
    match_o = valid_i && (data_q == op_i.value);
    data_d  = data_q;
    if (op_i.ins) begin
      if (!keep_o) begin
        data_d = left_keep_i ? op_i.value : left_data_i;
      end
    end else if (op_i.rem) begin
      if (op_i.found && valid_i && !(op_i.value < data_q)) begin
        data_d = right_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

@@ hdl/sorted_list_insert_remove.sv @@
// Top level of the descending sorted list built from a chain of cells.
//
// Input channel: in_valid_i / in_stall_o carry one request (in_data_i) per
// transfer: insert a value, remove the first equal entry, or clear the list.
// Output channel: out_valid_o / out_stall_i carry one result (out_data_o) per
// request: status, count, head value and tail value.
// A request updates the cells in the cycle of its transfer; once the cells
// are registered, the head and tail are gathered into the output register
// as soon as it is free. A new request is taken once the previous result
// has been loaded, so requests do not overlap. The tail select, an AND-OR
// over all cells, lies between the cell registers and the output register.
// When the receiver stalls, the result holds in the output register; the
// next request may still transfer, and its result waits until the output
// register frees up, with the input stalled meanwhile.
// Reset empties the list and clears both channels; cell contents are not
// reset and are never shown while the count excludes them.
module sorted_list_insert_remove #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  sli_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output sli_pkg::out_t out_data_o
);
  import sli_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]          count_q, count_d;
  logic                      pend_q;
  logic [STAT_W-1:0]         status_q, status_d;
  logic                      out_valid_q;
  out_t                      out_data_q;

  logic                      in_xfer, load_out, full, found;
  cell_op_t                  op;
  logic [CAPACITY-1:0]       keep, match, valid, tail_sel;
  logic signed [VALUE_W-1:0] cell_data [CAPACITY];
  logic signed [VALUE_W-1:0] tail_val;

  assign in_stall_o = pend_q;
  assign in_xfer    = in_valid_i && !pend_q;
  assign load_out   = pend_q && (!out_valid_q || !out_stall_i);
  assign full       = (count_q == CNT_W'(CAPACITY));
  assign found      = |match;

  always_comb begin
    op.ins   = in_xfer && (in_data_i.req_type == REQ_INSERT) && !full;
    op.rem   = in_xfer && (in_data_i.req_type == REQ_REMOVE);
    op.found = found;
    op.value = in_data_i.value;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign valid[i]    = (count_q > CNT_W'(i));
    assign tail_sel[i] = (count_q == CNT_W'(i + 1));
    if (i == 0) begin : g_head
      sli_cell u_cell (
        .clk_i        (clk_i),
        .op_i         (op),
        .valid_i      (valid[i]),
        .left_keep_i  (1'b1),
        .left_data_i  (in_data_i.value),
        .right_data_i (cell_data[(i + 1) % CAPACITY]),
        .keep_o       (keep[i]),
        .match_o      (match[i]),
        .data_o       (cell_data[i])
      );
    end else if (i == CAPACITY - 1) begin : g_tail
      sli_cell u_cell (
        .clk_i        (clk_i),
        .op_i         (op),
        .valid_i      (valid[i]),
        .left_keep_i  (keep[i-1]),
        .left_data_i  (cell_data[i-1]),
        .right_data_i (cell_data[i]),
        .keep_o       (keep[i]),
        .match_o      (match[i]),
        .data_o       (cell_data[i])
      );
    end else begin : g_mid
      sli_cell u_cell (
        .clk_i        (clk_i),
        .op_i         (op),
        .valid_i      (valid[i]),
        .left_keep_i  (keep[i-1]),
        .left_data_i  (cell_data[i-1]),
        .right_data_i (cell_data[i+1]),
        .keep_o       (keep[i]),
        .match_o      (match[i]),
        .data_o       (cell_data[i])
      );
    end
  end

  always_comb begin
    tail_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      tail_val = tail_val | (cell_data[i] & {VALUE_W{tail_sel[i]}});
    end
  end

  always_comb begin
    count_d  = count_q;
    status_d = ST_DONE;
    case (in_data_i.req_type)
      REQ_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end
      REQ_REMOVE: begin
        if (found) begin
          count_d = count_q - CNT_W'(1);
        end else begin
          status_d = ST_MISS;
        end
      end
      REQ_CLEAR: count_d = '0;
      default:   count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        count_q <= count_d;
        pend_q  <= 1'b1;
      end else if (load_out) begin
        pend_q  <= 1'b0;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      status_q <= status_d;
    end
    if (load_out) begin
      out_data_q.status   <= status_q;
      out_data_q.count    <= COUNT_W'(count_q);
      out_data_q.largest  <= (count_q == '0) ? '0 : cell_data[0];
      out_data_q.smallest <= tail_val;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
